FILE: hw/rtl/vcfe_pkg.sv
package vcfe_pkg;

  // Interior voxels along one chunk edge; the grid arrives padded by one on each side.
  localparam int EDGE_VOXELS = 16;
  localparam int SIDE        = EDGE_VOXELS + 2;
  localparam int PLANE       = SIDE * SIDE;
  localparam int ODEPTH      = 2 * PLANE;

  localparam int POS_W   = $clog2(SIDE);
  localparam int PADDR_W = $clog2(PLANE);

  localparam int COORD_W = 4;
  localparam int DIR_W   = 3;
  localparam int COLOR_W = 32;
  localparam int FC_W    = 15;
  localparam int FV_W    = FC_W + 2;
  localparam int NDIR    = 6;

  localparam logic [POS_W-1:0] POS_LO   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HI   = POS_W'(EDGE_VOXELS);
  localparam logic [POS_W-1:0] POS_XJ   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SIDE - 1);

  localparam logic [PADDR_W-1:0] PADDR_LAST = PADDR_W'(PLANE - 1);

  // Face direction codes
  localparam logic [DIR_W-1:0] DIR_XMIN = 3'd0;
  localparam logic [DIR_W-1:0] DIR_XMAX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_YMIN = 3'd2;
  localparam logic [DIR_W-1:0] DIR_YMAX = 3'd3;
  localparam logic [DIR_W-1:0] DIR_ZMIN = 3'd4;
  localparam logic [DIR_W-1:0] DIR_ZMAX = 3'd5;

  typedef logic [NDIR-1:0] face_mask_t;

endpackage

FILE: hw/rtl/vcfe_ram.sv
module vcfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // Read-first: a read of the address written in the same cycle returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

FILE: hw/rtl/voxel_cube_face_extractor.sv
// Voxel cube face extractor.
//
// Input channel (in_valid / in_stall): one beat per voxel of a chunk's padded
// grid, X slowest and Z fastest, carrying the voxel's outside bit and color.
// The voxel at (x, y, z) is judged when its +X neighbor arrives, one plane later.
// A solid interior voxel yields one face beat per outside neighbor on the result
// channel (out_valid / out_stall), in the order XMin, XMax, YMin, YMax, ZMin,
// ZMax; out_last_face marks the final face of the judged voxel.
// out_first_vertex is four times the number of faces already sent in the chunk.
// The first face of a voxel passes the input stage and then the output register.
// Throughput: one input beat per cycle when it triggers at most one face and the
// result is not stalled; after a beat triggering more, the next beat is taken as
// its last face leaves, as the result register takes one face per unstalled cycle.
// Outside bits sit in a two-plane shift line; colors sit in a one-plane RAM read
// at the address being rewritten.
// A stalled result holds in the output register while one more judged voxel
// waits in the input stage; in_stall is high while that stage owes faces beyond
// the one leaving this cycle.
// Reset (synchronous, rst_n low) clears positions, face count and valids; delay
// contents are not cleared, as no read reaches an entry not rewritten this chunk.
module voxel_cube_face_extractor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_outside,
  input  logic [vcfe_pkg::COLOR_W-1:0]  in_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vcfe_pkg::COORD_W-1:0]  out_voxel_x,
  output logic [vcfe_pkg::COORD_W-1:0]  out_voxel_y,
  output logic [vcfe_pkg::COORD_W-1:0]  out_voxel_z,
  output logic [vcfe_pkg::DIR_W-1:0]    out_face_dir,
  output logic [vcfe_pkg::COLOR_W-1:0]  out_face_color,
  output logic [vcfe_pkg::FV_W-1:0]     out_first_vertex,
  output logic                          out_last_face
);
  import vcfe_pkg::*;

  // Lowest set bit of the face mask gives the next direction.
  function automatic logic [DIR_W-1:0] first_dir(input face_mask_t m);
    logic [DIR_W-1:0] d;
    d = DIR_XMIN;
    for (int i = NDIR - 1; i >= 0; i--) begin
      if (m[i]) d = DIR_W'(i);
    end
    return d;
  endfunction

  // ---- position tracking and delay line ----
  logic [POS_W-1:0]   pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0]   pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [PADDR_W-1:0] cptr_r, cptr_nxt;
  logic [FC_W-1:0]    fc_r, fc_nxt;
  logic [ODEPTH-1:0]  oline_r;        // bit k-1 = outside bit of the beat k back
  logic               in_acc;
  logic               chunk_end;

  // ---- judge ----
  logic        interior;
  face_mask_t  nb;
  face_mask_t  mask_new;
  logic [FC_W-1:0] nfaces;

  // ---- input stage (judged voxel waiting to emit) ----
  logic               stg_vld_r, stg_vld_nxt;
  face_mask_t         stg_mask_r, stg_mask_nxt;
  logic [COORD_W-1:0] stg_x_r, stg_y_r, stg_z_r;
  logic [FC_W-1:0]    stg_fc_r, stg_fc_nxt;
  face_mask_t         stg_rest;
  logic               stg_last;
  logic               emit;
  logic [COLOR_W-1:0] ram_q;

  // ---- output register ----
  logic               out_vld_r, out_vld_nxt;
  logic [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [DIR_W-1:0]   out_dir_r;
  logic [COLOR_W-1:0] out_col_r;
  logic [FV_W-1:0]    out_fv_r;
  logic               out_last_r;

  assign in_acc = in_valid && !in_stall;

  assign chunk_end = (pos_z_r == POS_LAST) && (pos_y_r == POS_LAST) && (pos_x_r == POS_LAST);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (pos_z_r == POS_LAST) begin
      pos_z_nxt = '0;
      if (pos_y_r == POS_LAST) begin
        pos_y_nxt = '0;
        pos_x_nxt = (pos_x_r == POS_LAST) ? '0 : pos_x_r + POS_W'(1);
      end else begin
        pos_y_nxt = pos_y_r + POS_W'(1);
      end
    end else begin
      pos_z_nxt = pos_z_r + POS_W'(1);
    end
  end

  assign cptr_nxt = (cptr_r == PADDR_LAST) ? '0 : cptr_r + PADDR_W'(1);

  // Beat at padded (x, y, z) judges (x-1, y, z): neighbor taps sit at fixed depths.
  assign interior = (pos_x_r >= POS_XJ) &&
                    (pos_y_r >= POS_LO) && (pos_y_r <= POS_HI) &&
                    (pos_z_r >= POS_LO) && (pos_z_r <= POS_HI);

  always_comb begin
    nb[0] = oline_r[ODEPTH-1];        // x-1
    nb[1] = in_outside;               // x+1
    nb[2] = oline_r[PLANE+SIDE-1];    // y-1
    nb[3] = oline_r[PLANE-SIDE-1];    // y+1
    nb[4] = oline_r[PLANE];           // z-1
    nb[5] = oline_r[PLANE-2];         // z+1
  end

  assign mask_new = (interior && !oline_r[PLANE-1]) ? nb : '0;
  assign nfaces   = FC_W'($countones(mask_new));
  assign fc_nxt   = chunk_end ? '0 : fc_r + nfaces;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      cptr_r  <= '0;
      fc_r    <= '0;
    end else if (in_acc) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      cptr_r  <= cptr_nxt;
      fc_r    <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      oline_r <= {oline_r[ODEPTH-2:0], in_outside};
    end
  end

  // Color of the judged voxel: one plane back, at the address now rewritten.
  vcfe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PLANE)
  ) u_color_ram (
    .clk (clk),
    .we  (in_acc),
    .wa  (cptr_r),
    .wd  (in_color),
    .re  (in_acc),
    .ra  (cptr_r),
    .rd  (ram_q)
  );

  // ---- stage drain: one face per cycle into the output register unless stalled ----
  assign emit     = stg_vld_r && (!out_vld_r || !out_stall);
  assign stg_rest = stg_mask_r & (stg_mask_r - face_mask_t'(1));
  assign stg_last = (stg_rest == '0);
  assign in_stall = stg_vld_r && !(emit && stg_last);

  always_comb begin
    stg_vld_nxt  = stg_vld_r;
    stg_mask_nxt = stg_mask_r;
    stg_fc_nxt   = stg_fc_r;
    if (in_acc) begin
      stg_vld_nxt  = |mask_new;
      stg_mask_nxt = mask_new;
      stg_fc_nxt   = fc_r;
    end else if (emit) begin
      stg_vld_nxt  = !stg_last;
      stg_mask_nxt = stg_rest;
      stg_fc_nxt   = stg_fc_r + FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_mask_r <= stg_mask_nxt;
    stg_fc_r   <= stg_fc_nxt;
    if (in_acc) begin
      stg_x_r <= COORD_W'(pos_x_r - POS_XJ);
      stg_y_r <= COORD_W'(pos_y_r - POS_LO);
      stg_z_r <= COORD_W'(pos_z_r - POS_LO);
    end
  end

  // ---- output register ----
  assign out_vld_nxt = emit ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= stg_x_r;
      out_y_r    <= stg_y_r;
      out_z_r    <= stg_z_r;
      out_dir_r  <= first_dir(stg_mask_r);
      out_col_r  <= ram_q;
      out_fv_r   <= {stg_fc_r, 2'b00};
      out_last_r <= stg_last;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_voxel_x      = out_x_r;
  assign out_voxel_y      = out_y_r;
  assign out_voxel_z      = out_z_r;
  assign out_face_dir     = out_dir_r;
  assign out_face_color   = out_col_r;
  assign out_first_vertex = out_fv_r;
  assign out_last_face    = out_last_r;

endmodule

FILE: hw/rtl/vcfe_chk.sv
module vcfe_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [vcfe_pkg::COORD_W-1:0]  out_voxel_x,
  input logic [vcfe_pkg::COORD_W-1:0]  out_voxel_y,
  input logic [vcfe_pkg::COORD_W-1:0]  out_voxel_z,
  input logic [vcfe_pkg::DIR_W-1:0]    out_face_dir,
  input logic [vcfe_pkg::COLOR_W-1:0]  out_face_color,
  input logic [vcfe_pkg::FV_W-1:0]     out_first_vertex,
  input logic                          out_last_face
);
  import vcfe_pkg::*;

  // Stalled result beat holds its direction, vertex index and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_face_dir) &&
    $stable(out_first_vertex) && $stable(out_last_face))
    else $error("stalled result beat changed");

  // Faces of one voxel go out back to back.
  a_faces_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_face |=> out_valid)
    else $error("gap inside a voxel's face burst");

  // Within a voxel: same coordinates and color, rising direction, next vertex block.
  a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_face |=>
    (out_face_dir > $past(out_face_dir)) &&
    (out_voxel_x == $past(out_voxel_x)) && (out_voxel_y == $past(out_voxel_y)) &&
    (out_voxel_z == $past(out_voxel_z)) && (out_face_color == $past(out_face_color)) &&
    (out_first_vertex == $past(out_first_vertex) + FV_W'(4)))
    else $error("face burst out of order");

  // Legal direction code and quad-aligned vertex index.
  a_face_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face_dir <= DIR_ZMAX) && (out_first_vertex[1:0] == 2'b00))
    else $error("bad face direction or vertex index");

endmodule

bind voxel_cube_face_extractor vcfe_chk u_vcfe_chk (.*);
